// File: sv/plr_pkg.sv
// plr_pkg: shared types and constants for the palette line renderer.
// No dependencies; imported by every module of the block.
package plr_pkg;

  localparam int COORD_BITS = 12;
  localparam int IDX_BITS   = 8;
  localparam int COLOR_BITS = 16;
  localparam int PAL_DEPTH  = 1 << IDX_BITS;
  localparam int RUN_LIMIT  = 256;
  localparam int RUN_BITS   = $clog2(RUN_LIMIT + 1);

  localparam logic [2:0] RESTORE_METHOD = 3'd2;

  localparam logic [COORD_BITS-1:0] DISPLAY_WIDTH_RST  = COORD_BITS'(320);
  localparam logic [COORD_BITS-1:0] DISPLAY_HEIGHT_RST = COORD_BITS'(240);

  typedef enum logic [1:0] {
    OP_PAL_WRITE  = 2'd0,
    OP_LINE_START = 2'd1,
    OP_PIXEL      = 2'd2,
    OP_UNUSED     = 2'd3
  } opcode_t;

  typedef enum logic {
    REG_DISPLAY_WIDTH  = 1'b0,
    REG_DISPLAY_HEIGHT = 1'b1
  } reg_idx_t;

  // Pixel request between the line controller and the output register.
  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  start;
  } pix_req_t;

endpackage

// File: sv/plr_palette_ram.sv
// plr_palette_ram: 256 x RGB565 palette, one write port and one read port.
// Read data is registered. Depends on plr_pkg.
module plr_palette_ram
  import plr_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_BITS-1:0]   waddr,
  input  logic [COLOR_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [IDX_BITS-1:0]   raddr,
  output logic [COLOR_BITS-1:0] rdata
);

  logic [COLOR_BITS-1:0] mem [PAL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/plr_line_ctrl.sv
// plr_line_ctrl: line state, cropping, transparency and window tracking.
// Issues palette reads and holds the pending pixel request. Depends on plr_pkg.
module plr_line_ctrl
  import plr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  acc,
  input  logic                  advance,
  input  logic [1:0]            opcode,
  input  logic [COORD_BITS-1:0] origin_x,
  input  logic [COORD_BITS-1:0] origin_y,
  input  logic [COORD_BITS-1:0] line_row,
  input  logic [COORD_BITS-1:0] line_width,
  input  logic [2:0]            disposal,
  input  logic                  transparency_on,
  input  logic [IDX_BITS-1:0]   transparent_index,
  input  logic [IDX_BITS-1:0]   background_index,
  input  logic [IDX_BITS-1:0]   pixel_index,
  input  logic [COORD_BITS-1:0] display_width,
  input  logic [COORD_BITS-1:0] display_height,
  output logic                  rd_en,
  output logic [IDX_BITS-1:0]   rd_addr,
  output pix_req_t              req
);

  logic [COORD_BITS-1:0] line_x;
  logic [COORD_BITS:0]   line_y;
  logic [COORD_BITS-1:0] cropped_width;
  logic [COORD_BITS-1:0] pixel_position;
  logic                  line_live;
  logic                  skip_transparent;
  logic                  disposal_restore;
  logic [IDX_BITS-1:0]   held_transparent;
  logic [IDX_BITS-1:0]   held_background;
  logic [RUN_BITS-1:0]   run_count;
  logic                  in_run;

  opcode_t               op;
  logic [COORD_BITS:0]   y_sum;
  logic [COORD_BITS:0]   right_edge;
  logic                  ox_on;
  logic [COORD_BITS-1:0] w_crop;
  logic                  restore_new;
  logic                  pix_ok;
  logic [IDX_BITS-1:0]   idx_sub;
  logic                  is_transp;
  logic                  emit;
  logic                  start;
  logic                  run_restart;

  always_comb begin
    op          = opcode_t'(opcode);
    y_sum       = {1'b0, origin_y} + {1'b0, line_row};
    right_edge  = {1'b0, line_width} + {1'b0, origin_x};
    ox_on       = origin_x < display_width;
    w_crop      = (ox_on && right_edge > {1'b0, display_width}) ?
                  display_width - origin_x : line_width;
    restore_new = disposal == RESTORE_METHOD;

    pix_ok      = line_live && pixel_position < cropped_width;
    idx_sub     = (disposal_restore && pixel_index == held_transparent) ?
                  held_background : pixel_index;
    is_transp   = skip_transparent && idx_sub == held_transparent;
    run_restart = !in_run || run_count >= RUN_BITS'(RUN_LIMIT);
    start       = skip_transparent ? run_restart : !in_run;
    emit        = op == OP_PIXEL && pix_ok && !is_transp;

    rd_en       = acc && emit;
    rd_addr     = idx_sub;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_x           <= '0;
      line_y           <= '0;
      cropped_width    <= '0;
      pixel_position   <= '0;
      line_live        <= 1'b0;
      skip_transparent <= 1'b0;
      disposal_restore <= 1'b0;
      held_transparent <= '0;
      held_background  <= '0;
      run_count        <= '0;
      in_run           <= 1'b0;
      req              <= '0;
    end else begin
      if (acc) begin
        unique case (op)
          OP_LINE_START: begin
            line_x           <= origin_x;
            line_y           <= y_sum;
            cropped_width    <= w_crop;
            pixel_position   <= '0;
            run_count        <= '0;
            in_run           <= 1'b0;
            held_transparent <= transparent_index;
            held_background  <= background_index;
            disposal_restore <= restore_new;
            skip_transparent <= transparency_on && !restore_new;
            line_live        <= y_sum < {1'b0, display_height} && ox_on &&
                                w_crop != '0;
          end
          OP_PIXEL: begin
            if (pix_ok) begin
              pixel_position <= pixel_position + 1'b1;
              if (is_transp) begin
                in_run <= 1'b0;
              end else begin
                in_run <= 1'b1;
                if (skip_transparent) begin
                  run_count <= run_restart ? RUN_BITS'(1) : run_count + 1'b1;
                end
              end
            end
          end
          OP_PAL_WRITE, OP_UNUSED: begin
          end
          default: begin
          end
        endcase
        req.valid <= emit;
        req.x     <= line_x + pixel_position;
        req.y     <= line_y[COORD_BITS-1:0];
        req.start <= start;
      end else if (advance) begin
        req.valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/palette_line_renderer.sv
// palette_line_renderer: top level, APB register block, palette RAM,
// line controller and output register. Depends on plr_pkg, plr_palette_ram,
// plr_line_ctrl.
// Usage:
//  - Input channel (in_valid/in_stall) carries requests: palette writes,
//    line starts and pixels, selected by opcode. One request per clock while in_stall is low.
//  - Output channel (out_valid/out_stall) carries one pixel per opaque,
//    in-range pixel request: screen x/y, RGB565 color and run_start.
//  - Path: a pixel request's palette read is registered beside the pending
//    request, then both move into the output register, from which the
//    receiver takes the result.
//  - Throughput: one request per cycle while in_stall is low, set by the
//    palette read port and the line-state update.
//  - A palette write is visible to a pixel request in the very next cycle.
//  - When the receiver stalls a valid output, the output register and a full
//    pending request both hold; in_stall rises only when both are full.
//  - APB registers: display_width at 0x0, display_height at 0x4; write them
//    only while the block is idle.
//  - Reset (rst, synchronous): clears line state and pending output, restores
//    320 x 240. Palette contents are undefined until written; no clearing pass.
module palette_line_renderer
  import plr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // APB configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [IDX_BITS-1:0]   palette_slot,
  input  logic [COLOR_BITS-1:0] palette_color,
  input  logic [COORD_BITS-1:0] origin_x,
  input  logic [COORD_BITS-1:0] origin_y,
  input  logic [COORD_BITS-1:0] line_row,
  input  logic [COORD_BITS-1:0] line_width,
  input  logic [2:0]            disposal,
  input  logic                  transparency_on,
  input  logic [IDX_BITS-1:0]   transparent_index,
  input  logic [IDX_BITS-1:0]   background_index,
  input  logic [IDX_BITS-1:0]   pixel_index,
  // pixel channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] screen_x,
  output logic [COORD_BITS-1:0] screen_y,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  run_start
);

  logic [COORD_BITS-1:0] display_width;
  logic [COORD_BITS-1:0] display_height;
  reg_idx_t              reg_sel;
  logic                  cfg_wr;

  logic                  acc;
  logic                  advance;
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [COLOR_BITS-1:0] rd_data;
  pix_req_t              req;

  // ---- APB: registers on a 4-byte stride, low address bits ignored
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_sel)
      REG_DISPLAY_WIDTH:  prdata = {{(32-COORD_BITS){1'b0}}, display_width};
      REG_DISPLAY_HEIGHT: prdata = {{(32-COORD_BITS){1'b0}}, display_height};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= DISPLAY_WIDTH_RST;
      display_height <= DISPLAY_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DISPLAY_WIDTH:  display_width  <= pwdata[COORD_BITS-1:0];
        REG_DISPLAY_HEIGHT: display_height <= pwdata[COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---- flow control: the pending request moves whenever the output
  // register is empty or being drained; input stalls only when both are full
  assign advance  = !out_valid || !out_stall;
  assign in_stall = req.valid && !advance;
  assign acc      = in_valid && !in_stall;

  plr_palette_ram u_pal (
    .clk   (clk),
    .we    (acc && opcode_t'(opcode) == OP_PAL_WRITE),
    .waddr (palette_slot),
    .wdata (palette_color),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  plr_line_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .acc               (acc),
    .advance           (advance),
    .opcode            (opcode),
    .origin_x          (origin_x),
    .origin_y          (origin_y),
    .line_row          (line_row),
    .line_width        (line_width),
    .disposal          (disposal),
    .transparency_on   (transparency_on),
    .transparent_index (transparent_index),
    .background_index  (background_index),
    .pixel_index       (pixel_index),
    .display_width     (display_width),
    .display_height    (display_height),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .req               (req)
  );

  // ---- output register; RAM data lines up with the pending request
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      screen_x    <= req.x;
      screen_y    <= req.y;
      run_start   <= req.start;
      pixel_color <= rd_data;
    end
  end

endmodule

// File: tb/palette_line_renderer_tb.sv
// Testbench for palette_line_renderer: a directed stimulus table and random line traffic.
// Every pixel result is checked, against an in-bench renderer model or a typed-in answer.
// Depends on plr_pkg and palette_line_renderer only.
module palette_line_renderer_tb
  import plr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Run-shaping constants
  localparam int unsigned HOLD_CYCLES     = 160;  // long receiver hold-off
  localparam int unsigned DRAIN_PAUSE     = 6;    // > pipeline depth
  localparam int unsigned LONG_RUN_PIXELS = 560;  // crosses RUN_LIMIT twice
  localparam int unsigned MAX_REPORTS     = 100;  // keeps the log readable on a broken block
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned NUM_DIRECTED    = 26;

  // One request as the block sees it, all fields present whatever the opcode
  typedef struct packed {
    opcode_t                op;
    logic [IDX_BITS-1:0]    slot;
    logic [COLOR_BITS-1:0]  color;
    logic [COORD_BITS-1:0]  ox;
    logic [COORD_BITS-1:0]  oy;
    logic [COORD_BITS-1:0]  row;
    logic [COORD_BITS-1:0]  width;
    logic [2:0]             disposal;
    logic                   transp_on;
    logic [IDX_BITS-1:0]    transp_idx;
    logic [IDX_BITS-1:0]    bg_idx;
    logic [IDX_BITS-1:0]    pix_idx;
  } req_t;

  localparam int REQ_BITS = $bits(req_t);

  // One rendered pixel
  typedef struct packed {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [COLOR_BITS-1:0]  color;
    logic                   start;
  } pix_t;

  // How a table row is checked: by the model, against a typed-in answer, or not at all
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_PIX
  } chk_e;

  typedef struct packed {
    req_t  req;
    chk_e  mode;
    pix_t  pix;
  } stim_row_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_TOGGLE,
    RX_HOLD
  } rx_mode_e;

  // DUT signals; the inputs are all known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            opcode = '0;
  logic [IDX_BITS-1:0]   palette_slot = '0;
  logic [COLOR_BITS-1:0] palette_color = '0;
  logic [COORD_BITS-1:0] origin_x = '0;
  logic [COORD_BITS-1:0] origin_y = '0;
  logic [COORD_BITS-1:0] line_row = '0;
  logic [COORD_BITS-1:0] line_width = '0;
  logic [2:0]            disposal = '0;
  logic                  transparency_on = 1'b0;
  logic [IDX_BITS-1:0]   transparent_index = '0;
  logic [IDX_BITS-1:0]   background_index = '0;
  logic [IDX_BITS-1:0]   pixel_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [COORD_BITS-1:0] screen_x;
  logic [COORD_BITS-1:0] screen_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  run_start;

  palette_line_renderer dut (.*);

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // Renderer model state: its own copy of the palette, line and config
  // ---------------------------------------------------------------------
  logic [COLOR_BITS-1:0] pal_mem [PAL_DEPTH];
  int unsigned cfg_w = DISPLAY_WIDTH_RST;
  int unsigned cfg_h = DISPLAY_HEIGHT_RST;
  int unsigned ln_x, ln_y, ln_width, ln_pos, run_len;
  bit          ln_live, ln_skip, ln_restore, ln_in_run;
  logic [IDX_BITS-1:0] ln_transp, ln_bg;

  pix_t        pixel_q [$];       // pixels the block still owes us
  int unsigned mismatches = 0;
  int unsigned useful_items = 0;  // requests the block does not just drop
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;   // asks the receiver for one long hold-off

  // Renders one request into the model state; returns 1 when a pixel comes out.
  function automatic bit render_step(input req_t r, output pix_t p);
    int unsigned w, y, pos;
    logic [IDX_BITS-1:0] idx;
    bit start;
    p = '0;
    case (r.op)
      OP_PAL_WRITE: begin
        pal_mem[r.slot] = r.color;
        return 1'b0;
      end
      OP_LINE_START: begin
        w = r.width;
        y = (r.oy + 32'(r.row)) & 'h1FFF;
        // crop at the right edge of the display
        if (r.ox < cfg_w && w + r.ox > cfg_w) w = cfg_w - r.ox;
        ln_x       = r.ox;
        ln_y       = y;
        ln_width   = w & 'h1FFF;
        ln_pos     = 0;
        run_len    = 0;
        ln_in_run  = 1'b0;
        ln_transp  = r.transp_idx;
        ln_bg      = r.bg_idx;
        ln_restore = (r.disposal == RESTORE_METHOD);
        ln_skip    = r.transp_on && !ln_restore;
        ln_live    = (y < cfg_h) && (r.ox < cfg_w) && (w >= 1);
        return 1'b0;
      end
      OP_PIXEL: begin
        if (!ln_live || ln_pos >= ln_width) return 1'b0;
        pos    = ln_pos;
        ln_pos = (ln_pos + 1) & 'h1FFF;
        idx    = r.pix_idx;
        // restore-to-background swaps the transparent index for the background
        if (ln_restore && idx == ln_transp) idx = ln_bg;
        if (ln_skip) begin
          if (idx == ln_transp) begin
            ln_in_run = 1'b0;
            return 1'b0;
          end
          // a window opens after a gap and every RUN_LIMIT opaque pixels
          if (!ln_in_run || run_len >= RUN_LIMIT) begin
            start   = 1'b1;
            run_len = 1;
          end else begin
            start   = 1'b0;
            run_len = (run_len + 1) & 'h1FFF;
          end
        end else begin
          start = !ln_in_run;
        end
        ln_in_run = 1'b1;
        p.x     = COORD_BITS'(ln_x + pos);
        p.y     = COORD_BITS'(ln_y);
        p.color = pal_mem[idx];
        p.start = start;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Request builders; fields a request does not use carry random junk
  // ---------------------------------------------------------------------
  function automatic req_t scramble();
    logic [REQ_BITS-1:0] bits;
    bits = REQ_BITS'({$urandom(), $urandom(), $urandom(), $urandom()});
    return req_t'(bits);
  endfunction

  function automatic req_t make_pal(int unsigned slot, int unsigned color);
    req_t r;
    r       = scramble();
    r.op    = OP_PAL_WRITE;
    r.slot  = IDX_BITS'(slot);
    r.color = COLOR_BITS'(color);
    return r;
  endfunction

  function automatic req_t make_line(int unsigned ox, int unsigned oy, int unsigned row,
                                     int unsigned w, int unsigned disp, int unsigned ton,
                                     int unsigned tidx, int unsigned bg);
    req_t r;
    r            = scramble();
    r.op         = OP_LINE_START;
    r.ox         = COORD_BITS'(ox);
    r.oy         = COORD_BITS'(oy);
    r.row        = COORD_BITS'(row);
    r.width      = COORD_BITS'(w);
    r.disposal   = 3'(disp);
    r.transp_on  = ton[0];
    r.transp_idx = IDX_BITS'(tidx);
    r.bg_idx     = IDX_BITS'(bg);
    return r;
  endfunction

  function automatic req_t make_pix(int unsigned idx);
    req_t r;
    r         = scramble();
    r.op      = OP_PIXEL;
    r.pix_idx = IDX_BITS'(idx);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Request driver. Bursts of random length, random gaps between them.
  // Prediction happens at the accepting edge; the pixel shows up at a later
  // edge, past the pending request and the output register, so push and pop never meet in one step.
  // ---------------------------------------------------------------------
  task automatic push_request(input req_t r, input chk_e mode, input pix_t typed);
    pix_t p;
    bit   has_pix;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid          <= 1'b1;
    opcode            <= r.op;
    palette_slot      <= r.slot;
    palette_color     <= r.color;
    origin_x          <= r.ox;
    origin_y          <= r.oy;
    line_row          <= r.row;
    line_width        <= r.width;
    disposal          <= r.disposal;
    transparency_on   <= r.transp_on;
    transparent_index <= r.transp_idx;
    background_index  <= r.bg_idx;
    pixel_index       <= r.pix_idx;
    do @(posedge clk); while (in_stall);
    // dropped requests do not count toward the stimulus budget
    if (!(r.op == OP_UNUSED || (r.op == OP_PIXEL && (!ln_live || ln_pos >= ln_width))))
      useful_items++;
    has_pix = render_step(r, p);
    case (mode)
      CHK_MODEL: if (has_pix) pixel_q.push_back(p);
      CHK_PIX:   pixel_q.push_back(typed);
      default:   ;
    endcase
  endtask

  task automatic wait_drained();
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access; lands at the edge with pready high.
  task automatic cfg_write(input reg_idx_t idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val & 'hFFF);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_DISPLAY_WIDTH) cfg_w = val & 'hFFF;
    else cfg_h = val & 'hFFF;
    @(posedge clk);
  endtask

  // One random sequence: mostly well-formed lines, some palette updates,
  // some noise (off-screen lines, stray pixels, the unused opcode).
  task automatic stream_sequence();
    req_t        r;
    int unsigned kind, n, ox, ysum, oy, w, cropped, disp, ton, tidx, px, lim;
    bit          long_run;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6))
        push_request(make_pal($urandom_range(0, 255), $urandom_range(0, 65535)),
                     CHK_MODEL, '0);
    end else if (kind < 22) begin
      r    = scramble();
      r.op = opcode_t'($urandom_range(0, 3));
      push_request(r, CHK_MODEL, '0);
    end else begin
      long_run = (kind >= 95) && (cfg_w >= 300);
      if (cfg_w == 0) begin
        ox = $urandom_range(0, 4095);
      end else if (long_run) begin
        ox = $urandom_range(0, 8);
      end else if ($urandom_range(0, 3) == 0) begin
        // hug the right edge so cropping kicks in
        lim = (cfg_w - 1 < 8) ? cfg_w - 1 : 8;
        ox  = cfg_w - 1 - $urandom_range(0, lim);
      end else begin
        ox = $urandom_range(0, cfg_w - 1);
      end
      ysum = (cfg_h == 0) ? $urandom_range(0, 4094) : $urandom_range(0, cfg_h - 1);
      oy   = $urandom_range(0, ysum);
      if (long_run) w = 4095;
      else if ($urandom_range(0, 5) == 0) w = $urandom_range(1, 4095);
      else w = $urandom_range(1, 24);
      disp = long_run ? 0 : (($urandom_range(0, 3) == 0) ? RESTORE_METHOD
                                                         : $urandom_range(0, 7));
      ton  = long_run ? 1 : $urandom_range(0, 1);
      tidx = $urandom_range(0, 255);
      push_request(make_line(ox, oy, ysum - oy, w, disp, ton, tidx, $urandom_range(0, 255)),
                   CHK_MODEL, '0);
      cropped = (ox < cfg_w && w + ox > cfg_w) ? cfg_w - ox : w;
      if (long_run) begin
        n = (cropped < LONG_RUN_PIXELS) ? cropped : LONG_RUN_PIXELS;
      end else begin
        n = (cropped < 40) ? cropped : 40;
        // broken lines stop early; others run a few pixels past the end
        if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
        else n += $urandom_range(0, 3);
      end
      repeat (n) begin
        if (long_run) begin
          px = $urandom_range(0, 255);
          if (px == tidx) px ^= 1;
          if ($urandom_range(0, 199) == 0) px = tidx;
        end else begin
          px = ($urandom_range(0, 3) == 0) ? tidx : $urandom_range(0, 255);
        end
        push_request(make_pix(px), CHK_MODEL, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: stalls on its own pattern; one long hold-off on request so
  // the output register and the pending slot both fill and in_stall rises.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned seg_left;
    rx_mode_e    mode;
    seg_left = 0;
    mode     = RX_FREE;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        mode     = RX_HOLD;
        seg_left = HOLD_CYCLES;
      end else if (seg_left == 0) begin
        mode     = rx_mode_e'($urandom_range(0, 2));
        seg_left = $urandom_range(4, 40);
      end
      seg_left--;
      case (mode)
        RX_FREE:   out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        RX_TOGGLE: out_stall <= seg_left[0];
        default:   out_stall <= 1'b1;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pixel checker: oldest expectation against each accepted result
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pix_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("unexpected pixel x=%0d y=%0d color=%h run_start=%0b",
                 screen_x, screen_y, pixel_color, run_start);
      end else begin
        want = pixel_q.pop_front();
        if (screen_x !== want.x) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("screen_x: expected %0d, got %0d", want.x, screen_x);
        end
        if (screen_y !== want.y) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("screen_y: expected %0d, got %0d", want.y, screen_y);
        end
        if (pixel_color !== want.color) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("pixel_color: expected %h, got %h", want.color, pixel_color);
        end
        if (run_start !== want.start) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $error("run_start: expected %0b, got %0b", want.start, run_start);
        end
      end
    end
  end

  // Safety net: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    stim_row_t   dir_rows [NUM_DIRECTED];
    req_t        op3_req;
    int unsigned ph_w   [NUM_PHASES];
    int unsigned ph_h   [NUM_PHASES];
    int unsigned ph_end [NUM_PHASES];

    op3_req    = scramble();
    op3_req.op = OP_UNUSED;

    // Directed table, run at the reset display size of 320 x 240.
    dir_rows = '{
      // pixel with no live line, unused opcode
      '{make_pix(0),   CHK_NONE, '0},
      '{op3_req,       CHK_NONE, '0},
      // palette extremes plus one mid pattern
      '{make_pal(0, 16'h0000),   CHK_NONE, '0},
      '{make_pal(255, 16'hFFFF), CHK_NONE, '0},
      '{make_pal(1, 16'hA5A5),   CHK_NONE, '0},
      // transparent index 1: opaque, gap, new window, then past the width
      '{make_line(0, 0, 0, 3, 0, 1, 1, 0), CHK_NONE, '0},
      '{make_pix(255), CHK_PIX,  pix_t'{12'd0, 12'd0, 16'hFFFF, 1'b1}},
      '{make_pix(1),   CHK_NONE, '0},
      '{make_pix(0),   CHK_PIX,  pix_t'{12'd2, 12'd0, 16'h0000, 1'b1}},
      '{make_pix(0),   CHK_NONE, '0},
      // restore-to-background on the last row, cropped at the right edge
      '{make_line(318, 200, 39, 4095, RESTORE_METHOD, 1, 1, 255), CHK_NONE, '0},
      '{make_pix(1),   CHK_PIX,  pix_t'{12'd318, 12'd239, 16'hFFFF, 1'b1}},
      '{make_pix(0),   CHK_PIX,  pix_t'{12'd319, 12'd239, 16'h0000, 1'b0}},
      '{make_pix(0),   CHK_NONE, '0},
      // dropped lines: row below the display, origin past the edge, zero width
      '{make_line(0, 200, 40, 5, 0, 0, 0, 0), CHK_NONE, '0},
      '{make_pix(0),   CHK_NONE, '0},
      '{make_line(320, 0, 0, 5, 0, 0, 0, 0),  CHK_NONE, '0},
      '{make_pix(0),   CHK_NONE, '0},
      '{make_line(0, 0, 0, 0, 0, 0, 0, 0),    CHK_NONE, '0},
      '{make_pix(0),   CHK_NONE, '0},
      '{make_line(4095, 4095, 4095, 4095, 7, 1, 255, 255), CHK_NONE, '0},
      '{make_pix(0),   CHK_NONE, '0},
      // transparency off: index equal to the transparent one still draws
      '{make_line(5, 10, 0, 3, 0, 0, 0, 0), CHK_NONE, '0},
      '{make_pix(0),   CHK_PIX,  pix_t'{12'd5, 12'd10, 16'h0000, 1'b1}},
      '{make_pix(255), CHK_MODEL, '0},
      '{make_pix(1),   CHK_MODEL, '0}
    };

    // Display sizes per phase, extremes and zero sizes among them;
    // ph_end is the running budget of requests the block acts on.
    ph_w   = '{320, 1, 4095, 0, 320, 64, 0, 0};
    ph_h   = '{240, 1, 4095, 240, 0, 48, 0, 0};
    ph_end = '{300, 360, 560, 566, 572, 680, 780, 880};
    ph_w[6] = $urandom_range(1, 4095);
    ph_h[6] = $urandom_range(1, 4095);
    ph_w[7] = $urandom_range(300, 800);
    ph_h[7] = $urandom_range(1, 600);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) push_request(dir_rows[i].req, dir_rows[i].mode, dir_rows[i].pix);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // registers change only with the pipe empty
      in_valid <= 1'b0;
      @(posedge clk);
      wait_drained();
      repeat (DRAIN_PAUSE) @(posedge clk);
      cfg_write(REG_DISPLAY_WIDTH, ph_w[ph]);
      cfg_write(REG_DISPLAY_HEIGHT, ph_h[ph]);
      if (ph == 0) begin
        // load the whole palette so no lookup ever hits an unwritten entry
        for (int s = 0; s < PAL_DEPTH; s++)
          push_request(make_pal(s, $urandom_range(0, 65535)), CHK_MODEL, '0);
        hold_req = 1'b1;
      end
      while (useful_items < ph_end[ph]) begin
        stream_sequence();
        // mid-phase pauses (budget 480 to 499) until every pending pixel has come back
        if (ph == 2 && useful_items >= 480 && useful_items < 500) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
